### design/hof_pkg.sv
// ----------------------------------------------------------------------------
// hof_pkg: shared types and constants of the Hampel outlier filter
// Sample width, window depth, beat structs and sequencer states.
// ----------------------------------------------------------------------------
package hof_pkg;

  localparam int MAX_FLANK   = 7;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_MAX     = 2 * MAX_FLANK + 1;
  localparam int IDX_W       = $clog2(WIN_MAX);
  localparam int CNT_W       = $clog2(WIN_MAX + 1);
  localparam int FLANK_W     = 3;
  localparam int GAIN_W      = 8;
  localparam int DEV_W       = SAMPLE_BITS + 1;
  localparam int RANK_W      = $clog2(WIN_MAX + 1);

  localparam logic [0:0] REG_FLANK = 1'd0;
  localparam logic [0:0] REG_GAIN  = 1'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          end_of_run;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MED, ST_MAD, ST_DEC, ST_EMIT, ST_TAIL
  } state_t;

  // per-cycle controls for the cell row
  typedef struct packed {
    logic                 shift;
    logic                 use_dev;
    logic [CNT_W-1:0]     n;
  } cell_ctl_t;

endpackage

### design/hof_cell.sv
// ----------------------------------------------------------------------------
// hof_cell: one window cell
// Holds a sample, passes it to the next cell on shift, and ranks a broadcast
// key against its own value (or its absolute deviation from the median).
// ----------------------------------------------------------------------------
module hof_cell (
  input  logic                          clk,
  input  hof_pkg::cell_ctl_t            ctl,
  input  logic [hof_pkg::IDX_W-1:0]     pos,
  input  logic signed [hof_pkg::SAMPLE_BITS-1:0] d_in,
  input  logic signed [hof_pkg::DEV_W-1:0]       key,
  input  logic signed [hof_pkg::DEV_W-1:0]       med,
  output logic signed [hof_pkg::SAMPLE_BITS-1:0] d_out,
  output logic                          lt,
  output logic                          le
);
  import hof_pkg::*;

  logic signed [SAMPLE_BITS-1:0] data_r;
  logic signed [DEV_W-1:0]       own;
  logic signed [DEV_W:0]         diff;
  logic                          act;

  // shift register stage
  always_ff @(posedge clk) begin
    if (ctl.shift) data_r <= d_in;
  end

  assign d_out = data_r;
  assign diff  = {{2{data_r[SAMPLE_BITS-1]}}, data_r} - {med[DEV_W-1], med};
  assign act   = ({{(CNT_W-IDX_W){1'b0}}, pos} < ctl.n);

  // compare value: sample or |sample - median|
  always_comb begin
    if (ctl.use_dev)
      own = diff[DEV_W] ? DEV_W'(-diff) : diff[DEV_W-1:0];
    else
      own = {data_r[SAMPLE_BITS-1], data_r};
  end

  assign lt = act && (own < key);
  assign le = act && (own <= key);
endmodule

### design/hampel_outlier_filter.sv
// ----------------------------------------------------------------------------
// hampel_outlier_filter: streaming Hampel filter, top level
// Row of window cells, a candidate-scan sequencer that finds median and MAD
// by rank counting, a threshold test, and an output register.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// in_     | in  | in_valid/in_ready   | in_beat_t  (sample, last)
// out_    | out | out_valid/out_ready | out_beat_t (value, end_of_run)
// cfg_    | in  | cfg_we              | cfg_idx, cfg_wdata
//
// One beat at a time. For a sample with a full window and a nonzero flank,
// window cells are tried in turn as median, then as MAD, one candidate per
// cycle through the cell row's rank compare, until one ranks as the middle.
// Tail beats after a last input are emitted one by one, then a closing step.
// Output stalls hold the sequencer. Reset is synchronous, active low; window
// contents are not cleared.
module hampel_outlier_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hof_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hof_pkg::out_beat_t   out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_idx,
  input  logic [7:0]           cfg_wdata
);
  import hof_pkg::*;

  state_t state_r, state_nxt;
  logic [FLANK_W-1:0] flank_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic [IDX_W-1:0]   cand_r, cand_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic               last_r, last_nxt;
  logic signed [DEV_W-1:0] med_r, med_nxt, mad_r, mad_nxt;
  logic               ov_r, ov_nxt;
  out_beat_t          od_r, od_nxt;

  cell_ctl_t ctl;
  logic signed [SAMPLE_BITS-1:0] chain [WIN_MAX+1];
  logic [WIN_MAX-1:0] lt_v, le_v;
  logic signed [DEV_W-1:0] key;
  logic [RANK_W-1:0] n_lt, n_le;
  logic [CNT_W-1:0] n_win, half;
  logic signed [SAMPLE_BITS-1:0] cand_val, ctr_val;
  logic signed [DEV_W:0] cdiff;
  logic signed [DEV_W-1:0] cand_dev;
  logic hit, out_free, accept;
  logic [DEV_W+4:0] dev16;
  logic [DEV_W+GAIN_W-1:0] bound;
  logic signed [DEV_W:0] xdiff;
  logic [DEV_W-1:0] xabs;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flank_r <= FLANK_W'(3);
      gain_r  <= GAIN_W'(48);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FLANK: flank_r <= cfg_wdata[FLANK_W-1:0];
        REG_GAIN:  gain_r  <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_win   = CNT_W'({flank_r, 1'b1});
  assign half    = CNT_W'(flank_r);
  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept  = in_valid && in_ready;

  // cell row
  assign chain[0] = in_data.sample;
  assign ctl = '{shift: accept, use_dev: (state_r == ST_MAD), n: n_win};
  assign cand_val = chain[cand_r + 1'b1];
  assign ctr_val  = chain[{1'b0, flank_r} + 1'b1];
  assign cdiff    = {{2{cand_val[SAMPLE_BITS-1]}}, cand_val} - {med_r[DEV_W-1], med_r};
  assign cand_dev = cdiff[DEV_W] ? DEV_W'(-cdiff) : cdiff[DEV_W-1:0];
  assign key = (state_r == ST_MAD) ? cand_dev : {cand_val[SAMPLE_BITS-1], cand_val};

  for (genvar g = 0; g < WIN_MAX; g++) begin : g_cell
    hof_cell u_cell (
      .clk(clk), .ctl(ctl), .pos(IDX_W'(g)), .d_in(chain[g]),
      .key(key), .med(med_r), .d_out(chain[g+1]), .lt(lt_v[g]), .le(le_v[g])
    );
  end

  assign n_lt = RANK_W'($countones(lt_v));
  assign n_le = RANK_W'($countones(le_v));
  // candidate is the middle element when fewer than half+1 lie below it
  // and at least half+1 lie at or below it
  assign hit = (n_lt <= RANK_W'(half)) && (n_le > RANK_W'(half));

  // threshold test, exact integers
  assign xdiff = {{2{ctr_val[SAMPLE_BITS-1]}}, ctr_val} - {med_r[DEV_W-1], med_r};
  assign xabs  = xdiff[DEV_W] ? DEV_W'(-xdiff) : xdiff[DEV_W-1:0];
  assign dev16 = {1'b0, xabs, 4'b0};
  assign bound = gain_r * mad_r[DEV_W-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    cand_nxt  = cand_r;
    tail_nxt  = tail_r;
    last_nxt  = last_r;
    med_nxt   = med_r;
    mad_nxt   = mad_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_data.last;
          if (seen_r < CNT_W'(WIN_MAX)) seen_nxt = seen_r + 1'b1;
          cand_nxt = '0;
          state_nxt = ST_EMIT;
          if (seen_nxt >= n_win && flank_r != '0) state_nxt = ST_MED;
        end
      end
      ST_MED: begin
        if (hit) begin
          med_nxt = {cand_val[SAMPLE_BITS-1], cand_val};
          cand_nxt = '0;
          state_nxt = ST_MAD;
        end else begin
          cand_nxt = cand_r + 1'b1;
        end
      end
      ST_MAD: begin
        if (hit) begin
          mad_nxt = cand_dev;
          state_nxt = ST_DEC;
        end else begin
          cand_nxt = cand_r + 1'b1;
        end
      end
      ST_DEC: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.end_of_run = last_r && flank_r == '0;
          od_nxt.value = ((DEV_W+GAIN_W)'(dev16) < bound) ? ctr_val
                         : med_r[SAMPLE_BITS-1:0];
          state_nxt = ST_TAIL;
          tail_nxt  = IDX_W'((seen_r < half) ? seen_r : half);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          tail_nxt  = IDX_W'((seen_r < half) ? seen_r : half);
          state_nxt = ST_TAIL;
          if (seen_r > half) begin
            ov_nxt = 1'b1;
            od_nxt.value = ctr_val;
            od_nxt.end_of_run = last_r && flank_r == '0;
          end
        end
      end
      ST_TAIL: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (tail_r == '0) begin
          seen_nxt  = '0;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.value = chain[tail_r];
          od_nxt.end_of_run = (tail_r == IDX_W'(1));
          tail_nxt = tail_r - 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      ov_r    <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      ov_r    <= ov_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    tail_r <= tail_nxt;
    med_r  <= med_nxt;
    mad_r  <= mad_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // input only accepted while the sequencer idles
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == ST_IDLE) else $error("input taken while busy");
  // seen count never exceeds the window depth
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(WIN_MAX)) else $error("seen count overflow");
  // a pending result is held while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  // candidate scan stays within the window
  a_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MED || state_r == ST_MAD) |-> CNT_W'(cand_r) < n_win)
    else $error("candidate scan overran window");
endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Hampel outlier filter
// Drives sample sequences under random idle and stall, predicts every output
// beat with a behavioral Hampel filter, and checks the beats in order.
// ----------------------------------------------------------------------------
module tb_top;
  import hof_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_beat_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_beat_t          out_data;
  logic               cfg_we;
  logic [0:0]         cfg_idx;
  logic [7:0]         cfg_wdata;

  hampel_outlier_filter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic signed [SAMPLE_BITS-1:0] win_cells [WIN_MAX];
  int unsigned                   fill_count;
  logic [FLANK_W-1:0]            flank_reg;
  logic [GAIN_W-1:0]             gain_reg;
  out_beat_t                     filtered_q [$];
  int                            err_count;
  int                            beats_out;
  int                            beats_in;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  // median of the first n entries
  function automatic longint median_of(longint vals [WIN_MAX], int n);
    longint t;
    for (int i = 1; i < n; i++)
      for (int j = i; j > 0 && vals[j-1] > vals[j]; j--) begin
        t = vals[j]; vals[j] = vals[j-1]; vals[j-1] = t;
      end
    return vals[n/2];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] hampel_value(int fl);
    longint vals [WIN_MAX];
    longint med, mad, x, dev;
    int n;
    n = 2*fl + 1;
    for (int i = 0; i < WIN_MAX; i++) vals[i] = win_cells[i];
    med = median_of(vals, n);
    for (int i = 0; i < WIN_MAX; i++) begin
      dev = longint'(win_cells[i]) - med;
      vals[i] = dev < 0 ? -dev : dev;
    end
    mad = median_of(vals, n);
    x = win_cells[fl];
    dev = x - med;
    if (dev < 0) dev = -dev;
    if (dev * 16 < longint'(gain_reg) * mad) return x[SAMPLE_BITS-1:0];
    return med[SAMPLE_BITS-1:0];
  endfunction

  // push expected beats for one accepted input
  task automatic predict_beat(in_beat_t b);
    out_beat_t e;
    int fl;
    int tail;
    int n0;
    fl = flank_reg;
    n0 = filtered_q.size();
    for (int i = WIN_MAX-1; i > 0; i--) win_cells[i] = win_cells[i-1];
    win_cells[0] = b.sample;
    if (fill_count < WIN_MAX) fill_count++;
    if (fill_count > fl) begin
      e.end_of_run = 1'b0;
      e.value = (fill_count >= 2*fl+1) ? hampel_value(fl) : win_cells[fl];
      filtered_q.push_back(e);
    end
    if (b.last) begin
      tail = fill_count < fl ? fill_count : fl;
      while (tail > 0) begin
        tail--;
        e.value = win_cells[tail];
        e.end_of_run = 1'b0;
        filtered_q.push_back(e);
      end
      if (filtered_q.size() > n0) filtered_q[$].end_of_run = 1'b1;
      fill_count = 0;
    end
  endtask

  // valid stays up after acceptance until the next beat or an idle stretch
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic lst);
    in_beat_t b;
    int gap;
    b.sample = s; b.last = lst;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(b);
    beats_in++;
  endtask

  // drop valid, wait for all expected beats plus settle time
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (filtered_q.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    drain();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FLANK) flank_reg = val[FLANK_W-1:0];
    else gain_reg = val;
  endtask

  // output side: random stall, compare against oldest expectation
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        beats_out++;
        if (filtered_q.size() == 0) begin
          $error("unexpected beat value=%0d", out_data.value);
          err_count++;
        end else begin
          out_beat_t e;
          e = filtered_q.pop_front();
          if (e.value !== out_data.value) begin
            $error("value exp=%0d got=%0d", e.value, out_data.value);
            err_count++;
          end
          if (e.end_of_run !== out_data.end_of_run) begin
            $error("end_of_run exp=%0b got=%0b", e.end_of_run, out_data.end_of_run);
            err_count++;
          end
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (stall > 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (stall > 0) stall--;
        if (stall == 0) out_ready <= 1'b1;
      end
    end
  end

  task automatic send_run(int len, int mode);
    logic signed [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = SAMPLE_BITS'($urandom);
        1: s = SAMPLE_BITS'($urandom_range(0, 64) - 32);
        default: s = ($urandom_range(0, 5) == 0) ? SAMPLE_BITS'($urandom)
                     : SAMPLE_BITS'($urandom_range(0, 400) - 200);
      endcase
      send_sample(s, i == len-1);
    end
  endtask

  task automatic test_extremes();
    send_sample(16'sh7FFF, 1'b0); send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0); send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0); send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0); send_sample(16'sh0001, 1'b1);
  endtask

  task automatic test_outlier_and_flat();
    for (int i = 0; i < 9; i++) send_sample(i == 4 ? 16'sh4000 : 16'sh0100, i == 8);
    write_reg(REG_GAIN, 8'd0);
    send_run(7, 1);
  endtask

  task automatic test_flank_edges();
    write_reg(REG_FLANK, 8'd0);
    send_run(3, 0);
    write_reg(REG_FLANK, 8'd7);
    write_reg(REG_GAIN, 8'd255);
    send_run(4, 2);            // short sequence passes through
  endtask

  task automatic test_flank_change_midrun();
    write_reg(REG_FLANK, 8'd2);
    write_reg(REG_GAIN, 8'd48);
    send_run(6, 2);
    for (int i = 0; i < 8; i++)
      send_sample(SAMPLE_BITS'($urandom_range(0, 300) - 150), 1'b0);
    drain();
    cfg_we <= 1'b1; cfg_idx <= REG_FLANK; cfg_wdata <= 8'd1;
    @(posedge clk);
    cfg_we <= 1'b0; flank_reg = 3'd1;
    send_run(4, 2);
  endtask

  task automatic test_random();
    int len;
    while (beats_in < 120) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_FLANK, 8'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_GAIN, 8'($urandom));
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 24);
      send_run(len, $urandom_range(0, 2));
    end
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    err_count = 0; beats_out = 0; beats_in = 0;
    fill_count = 0; flank_reg = 3'd3; gain_reg = 8'd48;
    for (int i = 0; i < WIN_MAX; i++) win_cells[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_outlier_and_flat();
    test_flank_edges();
    test_flank_change_midrun();
    test_random();
    drain();
    $display("Sent %0d samples over flanks 0..7 and varied gains; checked %0d beats.",
             beats_in, beats_out);
    if (err_count == 0 && filtered_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/hof_pkg.sv
design/hof_cell.sv
design/hampel_outlier_filter.sv
verif/tb_top.sv
